// ===== design/frustum_corner_unprojector_defines.svh =====
// assertion helpers used by the checker file
`ifndef FRUSTUM_CORNER_UNPROJECTOR_DEFINES_SVH
`define FRUSTUM_CORNER_UNPROJECTOR_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define FCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcu check failed");

// next-cycle implication, held off while reset is low
`define FCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcu check failed");

`endif

// ===== design/fcu_pkg.sv =====
`default_nettype none

package fcu_pkg;

  // field and format widths
  localparam int unsigned LANE_W         = 16;
  localparam int unsigned COL_W          = 64;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned TOL_W          = 16;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned ONE_W          = 10;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  // matrix shape and vertex run
  localparam int unsigned N_ELEM = 16;
  localparam int unsigned N_AXIS = 3;
  localparam int unsigned N_CORNER = 8;

  localparam logic [3:0] LAST_ELEM   = 4'd15;
  localparam logic [1:0] LAST_COL    = 2'd3;
  localparam logic [1:0] W_ROW       = 2'd3;
  localparam logic [1:0] LAST_AXIS   = 2'd2;
  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [4:0] LAST_VTX    = 5'd23;

  // 1.0 in q8.8
  localparam int ONE_Q8 = 256;

  // saturation bounds in q16.16
  localparam logic [POS_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [COL_W-1:0] matrix_col3;
    logic [COL_W-1:0] matrix_col2;
    logic [COL_W-1:0] matrix_col1;
    logic [COL_W-1:0] matrix_col0;
    logic             force_rebuild;
  } in_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [2:0]              corner_index;
    logic                    divide_fault;
    logic                    last_vertex;
  } out_beat_t;

  typedef struct packed {
    logic                    fault;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } corner_row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ACC,
    S_DIV_INIT,
    S_DIV,
    S_EMIT_RD,
    S_EMIT_OUT
  } fcu_state_e;

  // corner visited by wireframe vertex k: near ring, far ring, then the four struts
  function automatic logic [2:0] edge_corner(input logic [4:0] k);
    logic [1:0] p;
    logic [2:0] c;
    p = k[2:1];
    unique case (k[4:3])
      2'b00, 2'b01: c = {k[3], k[0] ? p + 2'd1 : p};
      2'b10:        c = {k[0], p};
      default:      c = '0;
    endcase
    return c;
  endfunction

  // sign of clip coordinate for matrix column col at cube corner c (1 = minus)
  function automatic logic term_neg(input logic [2:0] c, input logic [1:0] col);
    logic n;
    unique case (col)
      2'd0:    n = (c[0] == c[1]);
      2'd1:    n = ~c[1];
      2'd2:    n = ~c[2];
      default: n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/frustum_corner_unprojector.sv =====
// channel  | signals                            | beat
// ---------+------------------------------------+----------------------------------
// in       | in_valid_i  in_ready_o  in_data_i  | one matrix and force bit
// out      | out_valid_o out_ready_i out_data_o | one wireframe vertex
// cfg      | cfg_we_i    cfg_wdata_i            | change tolerance, written at once
//
// an unchanged matrix with no force bit is compared and dropped with no vertex
// beats; a rebuild recomputes the corners and emits the wireframe vertices,
// stalling while out_ready_i is held low; the restoring divider yields one quotient
// bit a cycle. one item at a time: in_ready_o is low from accept until the last
// vertex beat, or until the compare ends for an unchanged matrix. reset loads the
// identity matrix and a zero tolerance; the corner store is not cleared.
`default_nettype none

module frustum_corner_unprojector #(
  parameter int unsigned ELEM_WIDTH = fcu_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire fcu_pkg::in_beat_t        in_data_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      fcu_pkg::out_beat_t       out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [fcu_pkg::TOL_W-1:0] cfg_wdata_i
);

  localparam int unsigned SW = (ELEM_WIDTH > fcu_pkg::ONE_W) ? ELEM_WIDTH : fcu_pkg::ONE_W;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = (DW > fcu_pkg::TOL_W) ? DW : fcu_pkg::TOL_W;
  localparam int unsigned AW = ELEM_WIDTH + 2;
  localparam int unsigned NW = AW + fcu_pkg::FRAC_W;
  localparam int unsigned QX = (NW > fcu_pkg::POS_W) ? NW : fcu_pkg::POS_W + 1;
  localparam int unsigned IW = $clog2(NW);
  localparam int unsigned FLAT_W = 4 * fcu_pkg::COL_W;

  localparam logic [IW-1:0] LAST_ITER = IW'(NW - 1);
  localparam logic [QX-1:0] LIM_POS = QX'(fcu_pkg::POS_MAX);
  localparam logic [QX-1:0] LIM_NEG = QX'(fcu_pkg::POS_MIN);

  fcu_pkg::fcu_state_e state_q, state_d;

  // control
  logic [3:0]        elem_q;
  logic              changed_q;
  logic [2:0]        corner_q;
  logic [1:0]        axis_q;
  logic [IW-1:0]     iter_q;
  logic [4:0]        vtx_q;
  logic              fault_q;
  logic [fcu_pkg::TOL_W-1:0] tol_q;

  // payload
  fcu_pkg::in_beat_t           in_q;
  logic signed [SW-1:0]        stored_q [fcu_pkg::N_ELEM];
  logic signed [AW-1:0]        sum_q;
  logic signed [AW-1:0]        acc_q [fcu_pkg::N_AXIS];
  logic signed [AW-1:0]        w_q;
  logic [AW-1:0]               rem_q;
  logic [NW-1:0]               nq_q;
  logic [AW-1:0]               dmag_q;
  logic                        nneg_q, nzero_q, wneg_q, wzero_q;
  logic signed [fcu_pkg::POS_W-1:0] pos_q [2];
  fcu_pkg::corner_row_t        corner_mem_q [fcu_pkg::N_CORNER];
  fcu_pkg::out_beat_t          out_q;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // split the incoming columns into lanes, index col*4 + row
  logic [FLAT_W-1:0]          flat_cols;
  logic signed [ELEM_WIDTH-1:0] lane_raw [fcu_pkg::N_ELEM];
  logic signed [SW-1:0]       lane_ext [fcu_pkg::N_ELEM];

  assign flat_cols = {in_q.matrix_col3, in_q.matrix_col2, in_q.matrix_col1, in_q.matrix_col0};

  always_comb begin
    for (int i = 0; i < fcu_pkg::N_ELEM; i++) begin
      lane_raw[i] = flat_cols[fcu_pkg::LANE_W*i +: ELEM_WIDTH];
      lane_ext[i] = SW'(lane_raw[i]);
    end
  end

  // shared element port: compare walks col-major, accumulate walks row-major
  logic [3:0]           stored_addr;
  logic signed [SW-1:0] stored_rd;
  logic [1:0]           acc_row, acc_col;

  assign acc_row     = elem_q[3:2];
  assign acc_col     = elem_q[1:0];
  assign stored_addr = (state_q == fcu_pkg::S_ACC) ? {acc_col, acc_row} : elem_q;
  assign stored_rd   = stored_q[stored_addr];

  // change detect, one element a cycle
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_abs;
  logic                 elem_chg, changed_nx, rebuild;

  always_comb begin
    diff       = DW'(lane_ext[elem_q]) - DW'(stored_rd);
    diff_abs   = diff[DW-1] ? -diff : diff;
    elem_chg   = CW'(diff_abs) > CW'(tol_q);
    changed_nx = changed_q | elem_chg;
    rebuild    = changed_nx | in_q.force_rebuild;
  end

  // row dot product with the corner signs, one term a cycle
  logic signed [AW-1:0] term, sum_base, sum_nx;

  always_comb begin
    term     = AW'(stored_rd);
    sum_base = (acc_col == 2'd0) ? '0 : sum_q;
    sum_nx   = fcu_pkg::term_neg(corner_q, acc_col) ? sum_base - term : sum_base + term;
  end

  // divider operand setup
  logic signed [AW-1:0] num_sel;
  logic [AW-1:0]        num_mag, w_mag;

  always_comb begin
    num_sel = acc_q[axis_q];
    num_mag = num_sel[AW-1] ? AW'(-num_sel) : AW'(num_sel);
    w_mag   = w_q[AW-1] ? AW'(-w_q) : AW'(w_q);
  end

  // restoring divide step on magnitudes
  logic [AW:0]   rem_sh, rem_sub;
  logic          q_bit;
  logic [AW-1:0] rem_nx;
  logic [NW-1:0] nq_nx;

  always_comb begin
    rem_sh  = {rem_q, nq_q[NW-1]};
    rem_sub = rem_sh - {1'b0, dmag_q};
    q_bit   = (rem_sh >= {1'b0, dmag_q});
    rem_nx  = q_bit ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
    nq_nx   = {nq_q[NW-2:0], q_bit};
  end

  // sign, saturation and zero-w handling of the finished quotient
  logic [QX-1:0]              qx;
  logic                       res_neg, div_fault, fault_all;
  logic [fcu_pkg::POS_W-1:0]  div_res;

  always_comb begin
    qx      = QX'(nq_nx);
    res_neg = nneg_q ^ wneg_q;
    priority if (wzero_q) begin
      div_fault = 1'b1;
      div_res   = nzero_q ? '0 : (nneg_q ? fcu_pkg::POS_MIN : fcu_pkg::POS_MAX);
    end else if (!res_neg && (qx > LIM_POS)) begin
      div_fault = 1'b1;
      div_res   = fcu_pkg::POS_MAX;
    end else if (res_neg && (qx > LIM_NEG)) begin
      div_fault = 1'b1;
      div_res   = fcu_pkg::POS_MIN;
    end else begin
      div_fault = 1'b0;
      div_res   = res_neg ? (fcu_pkg::POS_W'(0) - qx[fcu_pkg::POS_W-1:0])
                          : qx[fcu_pkg::POS_W-1:0];
    end
    fault_all = ((axis_q == 2'd0) ? 1'b0 : fault_q) | div_fault;
  end

  logic div_last;
  assign div_last = (iter_q == LAST_ITER);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fcu_pkg::S_IDLE: begin
        if (in_fire) state_d = fcu_pkg::S_CMP;
      end
      fcu_pkg::S_CMP: begin
        if (elem_q == fcu_pkg::LAST_ELEM) begin
          state_d = rebuild ? fcu_pkg::S_ACC : fcu_pkg::S_IDLE;
        end
      end
      fcu_pkg::S_ACC: begin
        if (elem_q == fcu_pkg::LAST_ELEM) state_d = fcu_pkg::S_DIV_INIT;
      end
      fcu_pkg::S_DIV_INIT: begin
        state_d = fcu_pkg::S_DIV;
      end
      fcu_pkg::S_DIV: begin
        if (div_last) begin
          priority if (axis_q != fcu_pkg::LAST_AXIS) state_d = fcu_pkg::S_DIV_INIT;
          else if (corner_q == fcu_pkg::LAST_CORNER)  state_d = fcu_pkg::S_EMIT_RD;
          else                                        state_d = fcu_pkg::S_ACC;
        end
      end
      fcu_pkg::S_EMIT_RD: begin
        state_d = fcu_pkg::S_EMIT_OUT;
      end
      fcu_pkg::S_EMIT_OUT: begin
        if (out_fire) begin
          state_d = (vtx_q == fcu_pkg::LAST_VTX) ? fcu_pkg::S_IDLE : fcu_pkg::S_EMIT_RD;
        end
      end
      default: state_d = fcu_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == fcu_pkg::S_IDLE);
    out_valid_o = (state_q == fcu_pkg::S_EMIT_OUT);
  end

  assign out_data_o = out_q;

  // sequencer counters, tolerance and stored matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcu_pkg::S_IDLE;
      elem_q    <= '0;
      changed_q <= 1'b0;
      corner_q  <= '0;
      axis_q    <= '0;
      iter_q    <= '0;
      vtx_q     <= '0;
      fault_q   <= 1'b0;
      tol_q     <= '0;
      for (int i = 0; i < fcu_pkg::N_ELEM; i++) begin
        stored_q[i] <= (i[3:2] == i[1:0]) ? SW'(fcu_pkg::ONE_Q8) : '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      unique case (state_q)
        fcu_pkg::S_IDLE: begin
          elem_q    <= '0;
          changed_q <= 1'b0;
          corner_q  <= '0;
          axis_q    <= '0;
          vtx_q     <= '0;
        end
        fcu_pkg::S_CMP: begin
          elem_q    <= elem_q + 4'd1;
          changed_q <= changed_nx;
          if ((elem_q == fcu_pkg::LAST_ELEM) && rebuild) begin
            for (int i = 0; i < fcu_pkg::N_ELEM; i++) stored_q[i] <= lane_ext[i];
          end
        end
        fcu_pkg::S_ACC: begin
          elem_q <= elem_q + 4'd1;
        end
        fcu_pkg::S_DIV_INIT: begin
          iter_q <= '0;
        end
        fcu_pkg::S_DIV: begin
          iter_q <= iter_q + IW'(1);
          if (div_last) begin
            fault_q <= fault_all;
            if (axis_q == fcu_pkg::LAST_AXIS) begin
              axis_q   <= '0;
              corner_q <= corner_q + 3'd1;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        fcu_pkg::S_EMIT_RD: begin
        end
        fcu_pkg::S_EMIT_OUT: begin
          if (out_fire) vtx_q <= vtx_q + 5'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
    unique case (state_q)
      fcu_pkg::S_ACC: begin
        sum_q <= sum_nx;
        if (acc_col == fcu_pkg::LAST_COL) begin
          if (acc_row == fcu_pkg::W_ROW) w_q <= sum_nx;
          else                           acc_q[acc_row] <= sum_nx;
        end
      end
      fcu_pkg::S_DIV_INIT: begin
        rem_q   <= '0;
        nq_q    <= {num_mag, fcu_pkg::FRAC_W'(0)};
        dmag_q  <= w_mag;
        nneg_q  <= num_sel[AW-1];
        nzero_q <= (num_sel == '0);
        wneg_q  <= w_q[AW-1];
        wzero_q <= (w_q == '0);
      end
      fcu_pkg::S_DIV: begin
        rem_q <= rem_nx;
        nq_q  <= nq_nx;
        if (div_last) begin
          if (axis_q == fcu_pkg::LAST_AXIS) begin
            corner_mem_q[corner_q] <= '{fault: fault_all, x: pos_q[0], y: pos_q[1],
                                         z: div_res};
          end else begin
            pos_q[axis_q[0]] <= div_res;
          end
        end
      end
      fcu_pkg::S_EMIT_RD: begin
        out_q.pos_x        <= corner_mem_q[fcu_pkg::edge_corner(vtx_q)].x;
        out_q.pos_y        <= corner_mem_q[fcu_pkg::edge_corner(vtx_q)].y;
        out_q.pos_z        <= corner_mem_q[fcu_pkg::edge_corner(vtx_q)].z;
        out_q.divide_fault <= corner_mem_q[fcu_pkg::edge_corner(vtx_q)].fault;
        out_q.corner_index <= fcu_pkg::edge_corner(vtx_q);
        out_q.last_vertex  <= (vtx_q == fcu_pkg::LAST_VTX);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/fcu_checker.sv =====
`default_nettype none

`include "frustum_corner_unprojector_defines.svh"

module fcu_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire fcu_pkg::out_beat_t out_data_o
);

  // no new matrix is taken while vertices are going out
  `FCU_ASSERT_IMP(a_busy_when_emitting, clk_i, rst_ni, out_valid_o, !in_ready_o)

  // an accepted matrix keeps the block busy for at least the next cycle
  `FCU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // the run always closes on the far strut corner
  `FCU_ASSERT_IMP(a_last_corner, clk_i, rst_ni, out_valid_o && out_data_o.last_vertex, out_data_o.corner_index == fcu_pkg::LAST_CORNER)

  // once the last vertex beat goes, the block is ready again
  `FCU_ASSERT_NXT(a_ready_after_run, clk_i, rst_ni, out_valid_o && out_ready_i && out_data_o.last_vertex, in_ready_o)

  // a stalled vertex beat holds
  `FCU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind frustum_corner_unprojector fcu_checker u_fcu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
